FILE: hdl/ssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssa_pkg;

    // Build constants
    localparam int MAX_SLOTS   = 16;
    localparam int STACK_BYTES = 65536;

    // The slot field is four bits wide, so no more than sixteen slots exist.
    localparam int SLOT_W   = 4;
    localparam int NUM_ENT  = 1 << SLOT_W;
    localparam int SLOT_CAP = (MAX_SLOTS < NUM_ENT) ? MAX_SLOTS : NUM_ENT;
    localparam int CNT_W    = SLOT_W + 1;
    localparam int ADDR_W   = 32;
    // Widest offset is SLOT_CAP * STACK_BYTES
    localparam int OFF_W    = $clog2(SLOT_CAP * STACK_BYTES + 1);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic {
        MODE_ALLOC   = 1'b0,
        MODE_RELEASE = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_CMP
    } t_state;

    // Update command to the slot table
    typedef struct packed {
        logic              set;
        logic              clr;
        logic              create;
        logic [SLOT_W-1:0] idx;
    } t_tbl_cmd;

endpackage

`default_nettype wire

FILE: hdl/ssa_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Busy flags and created-slot count.
module ssa_slot_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire ssa_pkg::t_tbl_cmd         i_cmd,
    input  wire logic [ssa_pkg::SLOT_W-1:0] i_rd_idx,
    output logic                           o_busy_bit,
    output logic [ssa_pkg::CNT_W-1:0]      o_created
);

    logic [ssa_pkg::NUM_ENT-1:0] r_busy;
    logic [ssa_pkg::CNT_W-1:0]   r_created;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_created <= '0;
        end else begin
            if (i_cmd.set) begin
                r_busy[i_cmd.idx] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_busy[i_cmd.idx] <= 1'b0;
            end
            if (i_cmd.create) begin
                r_created <= r_created + 1'b1;
            end
        end
    end

    assign o_busy_bit = r_busy[i_rd_idx];
    assign o_created  = r_created;

    a_created_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_created <= ssa_pkg::CNT_W'(ssa_pkg::SLOT_CAP))
        else $error("created count beyond slot limit");

    a_create_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.create |-> i_cmd.set && ({1'b0, i_cmd.idx} == r_created))
        else $error("new slot not taken at next index");

    a_no_set_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.set && i_cmd.clr))
        else $error("set and clear in same cycle");

endmodule

`default_nettype wire

FILE: hdl/stack_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Ports                                    Handshake
// --------   ---------  ---------------------------------------  ---------------------------
// request    in         i_mode, i_slot                           i_start & !o_busy
// result     out        o_slot_given, o_stack_base, o_status     o_done, one-cycle strobe
// config     in         i_cfg_data (stack top)                   i_cfg_valid & o_cfg_ready
//
// Release, and allocate with the stack top unset, finish in the scan state.
// Other allocates walk the busy flags one per cycle from the newest slot down;
// once a slot is picked (reused or new, also when its base would underflow)
// the multiply and compare states follow; when every slot exists and is busy
// the scan ends with full status.
// One multiply stage (index times slot size) and one compare/subtract stage
// against the stack top follow the scan.
// Reset (i_rst_n low, synchronous) frees all slots, clears the created count
// and the stack top. No clearing pass. o_cfg_ready is always high.
// The receiver cannot stall; o_busy is low again in the cycle o_done shows.
module stack_slot_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request
    input  wire logic                        i_start,
    output logic                             o_busy,
    input  wire logic                        i_mode,
    input  wire logic [ssa_pkg::SLOT_W-1:0]  i_slot,
    // result
    output logic                             o_done,
    output logic [ssa_pkg::SLOT_W-1:0]       o_slot_given,
    output logic [ssa_pkg::ADDR_W-1:0]       o_stack_base,
    output logic [1:0]                       o_status,
    // config
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [ssa_pkg::ADDR_W-1:0]  i_cfg_data
);

    ssa_pkg::t_state             r_state, n_state;
    logic [ssa_pkg::ADDR_W-1:0]  r_stack_top;

    // captured request
    logic                        r_mode, n_mode;
    logic [ssa_pkg::SLOT_W-1:0]  r_slot, n_slot;

    // scan pointer (one above the entry under test) and chosen slot
    logic [ssa_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [ssa_pkg::SLOT_W-1:0]  r_k, n_k;
    logic                        r_new, n_new;
    logic [ssa_pkg::OFF_W-1:0]   r_off, n_off;

    // result registers
    logic                        r_done, n_done;
    logic [ssa_pkg::SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic [ssa_pkg::ADDR_W-1:0]  r_res_base, n_res_base;
    ssa_pkg::t_status            r_res_st, n_res_st;

    ssa_pkg::t_tbl_cmd           w_cmd;
    logic [ssa_pkg::SLOT_W-1:0]  w_rd_idx;
    logic                        w_busy_bit;
    logic [ssa_pkg::CNT_W-1:0]   w_created;
    logic [ssa_pkg::ADDR_W-1:0]  w_off_ext;
    logic                        w_accept;

    assign w_accept  = i_start && (r_state == ssa_pkg::S_IDLE);
    assign w_rd_idx  = ssa_pkg::SLOT_W'(r_idx - 1'b1);
    assign w_off_ext = ssa_pkg::ADDR_W'(r_off);

    ssa_slot_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rd_idx   (w_rd_idx),
        .o_busy_bit (w_busy_bit),
        .o_created  (w_created)
    );

    // stack top register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_top <= '0;
        end else if (i_cfg_valid) begin
            r_stack_top <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = ssa_pkg::S_SCAN;
                end
            end
            ssa_pkg::S_SCAN: begin
                if (r_mode == ssa_pkg::MODE_RELEASE || r_stack_top == '0) begin
                    n_state = ssa_pkg::S_IDLE;
                end else if (r_idx == '0) begin
                    // nothing free: create, if room
                    if (w_created >= ssa_pkg::CNT_W'(ssa_pkg::SLOT_CAP)) begin
                        n_state = ssa_pkg::S_IDLE;
                    end else begin
                        n_state = ssa_pkg::S_MUL;
                    end
                end else if (!w_busy_bit) begin
                    n_state = ssa_pkg::S_MUL;
                end
            end
            ssa_pkg::S_MUL: begin
                n_state = ssa_pkg::S_CMP;
            end
            ssa_pkg::S_CMP: begin
                n_state = ssa_pkg::S_IDLE;
            end
            default: begin
                n_state = ssa_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mode     = r_mode;
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_k        = r_k;
        n_new      = r_new;
        n_off      = r_off;
        n_done     = 1'b0;
        n_res_slot = r_res_slot;
        n_res_base = r_res_base;
        n_res_st   = r_res_st;
        w_cmd      = '0;
        case (r_state)
            ssa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_mode = i_mode;
                    n_slot = i_slot;
                    n_idx  = w_created;
                end
            end
            ssa_pkg::S_SCAN: begin
                if (r_mode == ssa_pkg::MODE_RELEASE) begin
                    n_done     = 1'b1;
                    n_res_slot = r_slot;
                    n_res_base = '0;
                    if ({1'b0, r_slot} >= w_created) begin
                        n_res_st = ssa_pkg::ST_INVALID;
                    end else begin
                        n_res_st  = ssa_pkg::ST_OK;
                        w_cmd.clr = 1'b1;
                        w_cmd.idx = r_slot;
                    end
                end else if (r_stack_top == '0) begin
                    n_done     = 1'b1;
                    n_res_slot = '0;
                    n_res_base = '0;
                    n_res_st   = ssa_pkg::ST_INVALID;
                end else if (r_idx == '0) begin
                    if (w_created >= ssa_pkg::CNT_W'(ssa_pkg::SLOT_CAP)) begin
                        n_done     = 1'b1;
                        n_res_slot = '0;
                        n_res_base = '0;
                        n_res_st   = ssa_pkg::ST_FULL;
                    end else begin
                        n_k   = ssa_pkg::SLOT_W'(w_created);
                        n_new = 1'b1;
                    end
                end else if (!w_busy_bit) begin
                    n_k   = w_rd_idx;
                    n_new = 1'b0;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            ssa_pkg::S_MUL: begin
                // offset of slot k: (k + 1) * slot size
                n_off = ssa_pkg::OFF_W'(
                    int'({1'b0, r_k} + 1'b1) * ssa_pkg::STACK_BYTES);
            end
            ssa_pkg::S_CMP: begin
                n_done = 1'b1;
                if (w_off_ext > r_stack_top) begin
                    n_res_slot = '0;
                    n_res_base = '0;
                    n_res_st   = ssa_pkg::ST_FULL;
                end else begin
                    n_res_slot   = r_k;
                    n_res_base   = r_stack_top - w_off_ext;
                    n_res_st     = ssa_pkg::ST_OK;
                    w_cmd.set    = 1'b1;
                    w_cmd.create = r_new;
                    w_cmd.idx    = r_k;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssa_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_slot     <= n_slot;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_new      <= n_new;
        r_off      <= n_off;
        r_res_slot <= n_res_slot;
        r_res_base <= n_res_base;
        r_res_st   <= n_res_st;
    end

    assign o_busy       = (r_state != ssa_pkg::S_IDLE);
    assign o_done       = r_done;
    assign o_slot_given = r_res_slot;
    assign o_stack_base = r_res_base;
    assign o_status     = r_res_st;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("request taken but unit not busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result shown while still working");

    a_fail_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ssa_pkg::ST_OK) |-> (o_stack_base == '0))
        else $error("nonzero base on failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == ssa_pkg::ST_OK) || (o_status == ssa_pkg::ST_INVALID)
                   || (o_status == ssa_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

`default_nettype wire
